/* sv/pure_pursuit_lookahead_steer_top_defines.svh */
// Assertion macros shared by the steering block.
`ifndef PURE_PURSUIT_LOOKAHEAD_STEER_TOP_DEFINES_SVH
`define PURE_PURSUIT_LOOKAHEAD_STEER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pps_pkg.sv */
`timescale 1ns / 1ps
package pps_pkg;

  localparam int CNT_W     = 6;
  localparam int LA_W      = 19;
  localparam int TOL_W     = 10;
  localparam int MAXA_W    = 15;
  localparam int ANG_W     = 16;
  localparam int ZW        = 28;
  localparam int FRAC_Q    = 15;
  localparam int ANGLE_PI  = 25736;
  localparam int FRAC_FULL = 32767;
  localparam int PI_Q24    = 52707179;

  localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_MAX_ANGLE = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_SKIP, OP_SQX, OP_SQY, OP_SQA, OP_SQRT, OP_NOHIT,
    OP_DIRECT, OP_PREV, OP_MULX, OP_MULY, OP_DIVLD, OP_DIV, OP_SETX, OP_SETY,
    OP_CINIT, OP_CORD, OP_ANGLE, OP_FRLD, OP_FRSET, OP_EMIT_HIT, OP_EMIT_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic answered;
    logic last;
    logic hit_eq;
    logic hit_far;
    logic span_pos;
    logic frac_direct;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [LA_W-1:0]   lookahead;
    logic [TOL_W-1:0]  tol;
    logic [MAXA_W-1:0] max_angle;
  } cfg_t;

  // atan(2^-i) in 2^-24 rad
  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/pps_dp.sv */
`timescale 1ns / 1ps
module pps_dp #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pps_pkg::cmd_t                 cmd,
  input  pps_pkg::cfg_t                 cfg,
  output pps_pkg::status_t              status,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            steer_angle,
  output logic signed [15:0]            steer_fraction,
  output logic                          point_found
);
  import pps_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int RW = (W + 1 > 16) ? W + 1 : 16;
  localparam int DW = RW - 1;
  localparam int QW = W + 9;
  localparam int NB = W + 28;
  localparam int AW = W + 10;
  localparam int CW = W + 13;
  localparam int LW = (W > LA_W) ? W : LA_W;
  localparam int MW = W + LA_W;

  logic signed [W-1:0]     px, py, cx, cy;
  logic [W-1:0]            pd;
  logic                    clast, answered;
  logic [2*W-1:0]          prod, sumsq, srad;
  logic [W+1:0]            srem;
  logic [W-1:0]            root;
  logic [MW-1:0]           mprod;
  logic                    msign;
  logic [RW-1:0]           drem;
  logic [QW-1:0]           dsh;
  logic [DW-1:0]           dden;
  logic signed [AW-1:0]    ax, ay;
  logic signed [CW-1:0]    ca, cb;
  logic signed [ZW-1:0]    cz;
  logic                    zero_pt;
  logic signed [ANG_W-1:0] ang, frac;

  // magnitudes for the squares
  logic [W-1:0] ux, uy;
  assign ux = cx[W-1] ? W'(-cx) : W'(cx);
  assign uy = cy[W-1] ? W'(-cy) : W'(cy);

  // square root step
  logic [W+1:0] rem2, trial;
  logic         sq_ge;
  assign rem2  = {srem[W-1:0], srad[2*W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign sq_ge = rem2 >= trial;

  // look-ahead decision
  logic [LW:0] dext, lext, pext, diff;
  logic [LW:0] num_w;
  logic [LA_W-1:0] num;
  assign dext  = (LW + 1)'(root);
  assign lext  = (LW + 1)'(cfg.lookahead);
  assign pext  = (LW + 1)'(pd);
  assign diff  = (dext > lext) ? dext - lext : lext - dext;
  assign num_w = (lext > pext) ? lext - pext : '0;
  assign num   = num_w[LA_W-1:0];

  // interpolation span
  logic signed [W:0] dx, dy, dsel, negd;
  logic [W-1:0]      dmag;
  logic [W-1:0]      den;
  logic [NB-1:0]     nint, nsh;
  assign dx   = (W + 1)'(cx) - (W + 1)'(px);
  assign dy   = (W + 1)'(cy) - (W + 1)'(py);
  assign dsel = (cmd.op == OP_MULY) ? dy : dx;
  assign negd = -dsel;
  assign dmag = dsel[W] ? negd[W-1:0] : dsel[W-1:0];
  assign den  = root - pd;
  assign nint = NB'({mprod, 8'h00}) + NB'(den >> 1);
  assign nsh  = nint >> QW;

  // shared restoring divider step
  logic [RW-1:0] drem2;
  logic          dv_ge;
  assign drem2 = {drem[RW-2:0], dsh[QW-1]};
  assign dv_ge = drem2 >= {1'b0, dden};

  logic signed [AW-1:0] qs, qterm;
  assign qs    = AW'(dsh);
  assign qterm = msign ? -qs : qs;

  // cordic rotation
  logic signed [CW-1:0] sa, sb;
  logic [4:0]           cidx;
  assign cidx = cmd.cnt[4:0];
  assign sa   = cb >>> cidx;
  assign sb   = ca >>> cidx;

  // angle rounding
  logic [ZW-1:0]         zm, zr;
  logic [15:0]           zc;
  logic signed [ANG_W-1:0] zs;
  assign zm = cz[ZW-1] ? ZW'(-cz) : ZW'(cz);
  assign zr = (zm + ZW'(1024)) >> 11;
  assign zc = (zr > ZW'(ANGLE_PI)) ? 16'(ANGLE_PI) : zr[15:0];
  assign zs = ANG_W'(zc);

  // fraction
  logic signed [ANG_W-1:0] nang, dfrac, fq16;
  logic [FRAC_Q-1:0]       am;
  logic [30:0]             fn;
  logic                    sat;
  assign nang  = -ang;
  assign am    = ang[15] ? nang[14:0] : ang[14:0];
  assign fn    = {1'b0, am, 15'd0} - {16'd0, am} + {17'd0, cfg.max_angle[14:1]};
  assign sat   = fn >= {1'b0, cfg.max_angle, 15'd0};
  assign dfrac = (ang == '0) ? '0 : (ang[15] ? -16'(FRAC_FULL) : 16'(FRAC_FULL));
  assign fq16  = {1'b0, dsh[FRAC_Q-1:0]};

  always_comb begin
    status.answered    = answered;
    status.last        = clast;
    status.hit_eq      = diff <= (LW + 1)'(cfg.tol);
    status.hit_far     = dext > lext;
    status.span_pos    = root > pd;
    status.frac_direct = (cfg.max_angle == '0) || sat;
    status.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      answered  <= 1'b0;
      px        <= '0;
      py        <= '0;
      pd        <= '0;
    end else begin
      if (cmd.op == OP_EMIT_HIT || cmd.op == OP_EMIT_NONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_ACCEPT: begin
          cx    <= point_x;
          cy    <= point_y;
          clast <= last_point;
        end
        OP_SKIP: begin
          if (clast) begin
            answered <= 1'b0;
            px       <= '0;
            py       <= '0;
            pd       <= '0;
          end
        end
        OP_SQX: prod <= (2 * W)'(ux) * (2 * W)'(ux);
        OP_SQY: begin
          sumsq <= prod;
          prod  <= (2 * W)'(uy) * (2 * W)'(uy);
        end
        OP_SQA: begin
          srad <= sumsq + prod;
          srem <= '0;
          root <= '0;
        end
        OP_SQRT: begin
          srem <= sq_ge ? rem2 - trial : rem2;
          root <= {root[W-2:0], sq_ge};
          srad <= srad << 2;
        end
        OP_NOHIT: begin
          px <= cx;
          py <= cy;
          pd <= root;
        end
        OP_DIRECT: begin
          ax <= AW'(cx) <<< 8;
          ay <= AW'(cy) <<< 8;
        end
        OP_PREV: begin
          ax <= AW'(px) <<< 8;
          ay <= AW'(py) <<< 8;
        end
        OP_MULX, OP_MULY: begin
          mprod <= MW'(dmag) * MW'(num);
          msign <= dsel[W];
        end
        OP_DIVLD: begin
          drem <= nsh[RW-1:0];
          dsh  <= nint[QW-1:0];
          dden <= DW'(den);
        end
        OP_DIV: begin
          drem <= dv_ge ? drem2 - {1'b0, dden} : drem2;
          dsh  <= {dsh[QW-2:0], dv_ge};
        end
        OP_SETX: ax <= (AW'(px) <<< 8) + qterm;
        OP_SETY: ay <= (AW'(py) <<< 8) + qterm;
        OP_CINIT: begin
          zero_pt <= (ax == '0) && (ay == '0);
          if (ay[AW-1]) begin
            ca <= -CW'(ay);
            cb <= -CW'(ax);
            cz <= ax[AW-1] ? -ZW'(PI_Q24) : ZW'(PI_Q24);
          end else begin
            ca <= CW'(ay);
            cb <= CW'(ax);
            cz <= '0;
          end
        end
        OP_CORD: begin
          if (!cb[CW-1]) begin
            ca <= ca + sa;
            cb <= cb - sb;
            cz <= cz + atan_q24(cidx);
          end else begin
            ca <= ca - sa;
            cb <= cb + sb;
            cz <= cz - atan_q24(cidx);
          end
        end
        OP_ANGLE: ang <= zero_pt ? '0 : (cz[ZW-1] ? -zs : zs);
        OP_FRLD: begin
          frac <= dfrac;
          drem <= RW'(fn[30:15]);
          dsh  <= {fn[FRAC_Q-1:0], {(QW - FRAC_Q){1'b0}}};
          dden <= DW'(cfg.max_angle);
        end
        OP_FRSET: frac <= ang[15] ? -fq16 : fq16;
        OP_EMIT_HIT: begin
          steer_angle    <= ang;
          steer_fraction <= frac;
          point_found    <= 1'b1;
          answered       <= !clast;
          if (clast) begin
            px <= '0;
            py <= '0;
            pd <= '0;
          end
        end
        OP_EMIT_NONE: begin
          steer_angle    <= '0;
          steer_fraction <= '0;
          point_found    <= 1'b0;
          answered       <= 1'b0;
          px             <= '0;
          py             <= '0;
          pd             <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/pps_ctrl.sv */
`timescale 1ns / 1ps
`include "pure_pursuit_lookahead_steer_top_defines.svh"
module pps_ctrl #(
  parameter int COORD_WIDTH  = 20,
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pps_pkg::status_t status,
  output pps_pkg::cmd_t    cmd
);
  import pps_pkg::*;

  localparam int QW = COORD_WIDTH + 9;

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001, S_CHECK = 22'h000002, S_SQY   = 22'h000004,
    S_SQA   = 22'h000008, S_SQRT  = 22'h000010, S_DEC   = 22'h000020,
    S_MULX  = 22'h000040, S_LDX   = 22'h000080, S_DIVX  = 22'h000100,
    S_SETX  = 22'h000200, S_MULY  = 22'h000400, S_LDY   = 22'h000800,
    S_DIVY  = 22'h001000, S_SETY  = 22'h002000, S_CINIT = 22'h004000,
    S_CORD  = 22'h008000, S_ANG   = 22'h010000, S_FRLD  = 22'h020000,
    S_FRDIV = 22'h040000, S_FRSET = 22'h080000, S_EMITH = 22'h100000,
    S_EMITN = 22'h200000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  op_t              op;

  assign in_ready = (state == S_IDLE);
  assign cmd.op   = op;
  assign cmd.cnt  = cnt;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_ACCEPT;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.answered) begin
          op         = OP_SKIP;
          state_next = S_IDLE;
        end else begin
          op         = OP_SQX;
          state_next = S_SQY;
        end
      end
      S_SQY: begin
        op         = OP_SQY;
        state_next = S_SQA;
      end
      S_SQA: begin
        op         = OP_SQA;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        op = OP_SQRT;
        if (cnt == CNT_W'(COORD_WIDTH - 1)) state_next = S_DEC;
      end
      S_DEC: begin
        if (status.hit_eq) begin
          op         = OP_DIRECT;
          state_next = S_CINIT;
        end else if (status.hit_far) begin
          if (status.span_pos) begin
            state_next = S_MULX;
          end else begin
            op         = OP_PREV;
            state_next = S_CINIT;
          end
        end else begin
          op         = OP_NOHIT;
          state_next = status.last ? S_EMITN : S_IDLE;
        end
      end
      S_MULX: begin
        op         = OP_MULX;
        state_next = S_LDX;
      end
      S_LDX: begin
        op         = OP_DIVLD;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        op = OP_DIV;
        if (cnt == CNT_W'(QW - 1)) state_next = S_SETX;
      end
      S_SETX: begin
        op         = OP_SETX;
        state_next = S_MULY;
      end
      S_MULY: begin
        op         = OP_MULY;
        state_next = S_LDY;
      end
      S_LDY: begin
        op         = OP_DIVLD;
        state_next = S_DIVY;
      end
      S_DIVY: begin
        op = OP_DIV;
        if (cnt == CNT_W'(QW - 1)) state_next = S_SETY;
      end
      S_SETY: begin
        op         = OP_SETY;
        state_next = S_CINIT;
      end
      S_CINIT: begin
        op         = OP_CINIT;
        state_next = S_CORD;
      end
      S_CORD: begin
        op = OP_CORD;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = S_ANG;
      end
      S_ANG: begin
        op         = OP_ANGLE;
        state_next = S_FRLD;
      end
      S_FRLD: begin
        op         = OP_FRLD;
        state_next = status.frac_direct ? S_EMITH : S_FRDIV;
      end
      S_FRDIV: begin
        op = OP_DIV;
        if (cnt == CNT_W'(FRAC_Q - 1)) state_next = S_FRSET;
      end
      S_FRSET: begin
        op         = OP_FRSET;
        state_next = S_EMITH;
      end
      S_EMITH: begin
        // hold until the output word is free
        if (status.out_free) begin
          op         = OP_EMIT_HIT;
          state_next = S_IDLE;
        end
      end
      S_EMITN: begin
        if (status.out_free) begin
          op         = OP_EMIT_NONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cnt_next = (state_next != state) ? '0 : cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `PPS_ASSERT_NEXT(a_accept_check, in_valid && in_ready, state == S_CHECK, "accept did not start")
  `PPS_ASSERT_NEXT(a_sqrt_len, state == S_SQRT && cnt == CNT_W'(COORD_WIDTH - 1), state == S_DEC, "sqrt overran")
  `PPS_ASSERT_NOW(a_emit_free, op == OP_EMIT_HIT || op == OP_EMIT_NONE, status.out_free, "output overwritten")
  `PPS_ASSERT_NEXT(a_emit_done, (state == S_EMITH || state == S_EMITN) && status.out_free, state == S_IDLE, "emit stuck")

endmodule

/* sv/pure_pursuit_lookahead_steer_top.sv */
`timescale 1ns / 1ps
// Pure pursuit look-ahead search with steering angle and steering fraction.
// Input channel (in_valid/in_ready): one path point a word, point_x, point_y and
// last_point on the final point of a path. Output channel (out_valid/out_ready):
// steer_angle, steer_fraction and point_found, at most one word a path.
// One point is worked at a time; in_ready is high only while the block is idle.
// Work a point, COORD_WIDTH = W, CORDIC_STEPS = S: a point after a hit is
// skipped; a point short of the look-ahead is recorded (and on the last point
// of a path a no-hit word is sent); a direct hit and an interpolated hit both
// run the CORDIC and the fraction, and the fraction divide is skipped when the
// fraction saturates or full lock is zero. The steps are the bit-serial square
// root (W steps), the shared divider (W + 9 steps per axis, 15 for the
// fraction) and the iterative CORDIC (S steps).
// A result word waits in the output register; the next point is accepted while
// it waits, and the block only holds in its emit step if a second result is
// ready before the first is taken.
// Reset clears the path state and loads the register defaults (look-ahead
// 3000 mm, tolerance 1 mm, full lock 3574). Configuration by APB: lookahead_mm
// at 0x0, equal_tolerance_mm at 0x4, max_steer_angle at 0x8; write only idle.
module pure_pursuit_lookahead_steer_top #(
  parameter int COORD_WIDTH  = 20,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            steer_angle,
  output logic signed [15:0]            steer_fraction,
  output logic                          point_found
);
  import pps_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lookahead <= LA_W'(3000);
      cfg.tol       <= TOL_W'(1);
      cfg.max_angle <= MAXA_W'(3574);
    end else if (wr) begin
      case (paddr[3:2])
        REG_LOOKAHEAD: cfg.lookahead <= pwdata[LA_W-1:0];
        REG_TOLERANCE: cfg.tol       <= pwdata[TOL_W-1:0];
        REG_MAX_ANGLE: cfg.max_angle <= pwdata[MAXA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOOKAHEAD: prdata = 32'(cfg.lookahead);
      REG_TOLERANCE: prdata = 32'(cfg.tol);
      REG_MAX_ANGLE: prdata = 32'(cfg.max_angle);
      default:       prdata = '0;
    endcase
  end

  pps_ctrl #(
    .COORD_WIDTH (COORD_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  pps_dp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .status        (status),
    .point_x       (point_x),
    .point_y       (point_y),
    .last_point    (last_point),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .steer_angle   (steer_angle),
    .steer_fraction(steer_fraction),
    .point_found   (point_found)
  );

endmodule

/* dv/pure_pursuit_lookahead_steer_top_tb.sv */
`timescale 1ns / 1ps
module pure_pursuit_lookahead_steer_top_tb;
  import pps_pkg::*;

  localparam int  CW       = 20;
  localparam int  STEPS    = 16;
  localparam int  SETTLE   = 200;
  localparam real PERIOD   = 20.0;
  localparam longint XMIN  = -524288;
  localparam longint XMAX  = 524287;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] fraction;
    logic               found;
  } steer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic                 last_point = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [15:0]   steer_angle;
  logic signed [15:0]   steer_fraction;
  logic                 point_found;

  pure_pursuit_lookahead_steer_top #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) u_top (.*);

  // local copies of the registers and the path state
  longint la_mm, tol_mm, max_ang;
  longint prev_x, prev_y, prev_dist;
  bit     answered;
  steer_t steer_q[$];
  int     fail_cnt = 0;
  bit     in_gaps = 1'b1;
  bit     out_stalls = 1'b1;
  int     stall_left = 0;

  longint atan_q24_tab[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  initial forever #(PERIOD / 2) clk = ~clk;

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // round half away from zero, d > 0
  function automatic longint round_div(longint n, longint d);
    longint q;
    q = ((n < 0 ? -n : n) + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint heading_angle(longint sx, longint fy);
    longint a, b, z, da, db;
    a = fy;
    b = sx;
    z = 0;
    if (sx == 0 && fy == 0) return 0;
    if (a < 0) begin
      z = (b >= 0) ? PI_Q24 : -PI_Q24;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da;
        b -= db;
        z += atan_q24_tab[i];
      end else begin
        a -= da;
        b += db;
        z -= atan_q24_tab[i];
      end
    end
    z = round_div(z, 2048);
    if (z > ANGLE_PI) z = ANGLE_PI;
    if (z < -ANGLE_PI) z = -ANGLE_PI;
    return z;
  endfunction

  function automatic steer_t make_steer(longint ang, bit found);
    steer_t s;
    longint fr;
    if (max_ang == 0) fr = ang > 0 ? FRAC_FULL : (ang < 0 ? -FRAC_FULL : 0);
    else fr = round_div(ang * FRAC_FULL, max_ang);
    if (fr > FRAC_FULL) fr = FRAC_FULL;
    if (fr < -FRAC_FULL) fr = -FRAC_FULL;
    s.angle = ang[15:0];
    s.fraction = fr[15:0];
    s.found = found;
    return s;
  endfunction

  function automatic void clear_path();
    prev_x = 0;
    prev_y = 0;
    prev_dist = 0;
    answered = 1'b0;
  endfunction

  // advance the path state by one point and queue any steering word it causes
  function automatic void track_point(longint x, longint y, bit last);
    longint d, diff, num, den, ax, ay;
    bit hit;
    hit = 1'b0;
    ax = 0;
    ay = 0;
    if (answered) begin
      if (last) clear_path();
      return;
    end
    d = int_sqrt(x * x + y * y);
    diff = d > la_mm ? d - la_mm : la_mm - d;
    if (diff <= tol_mm) begin
      ax = x * 256;
      ay = y * 256;
      hit = 1'b1;
    end else if (d > la_mm) begin
      num = la_mm > prev_dist ? la_mm - prev_dist : 0;
      ax = prev_x * 256;
      ay = prev_y * 256;
      if (d > prev_dist) begin
        den = d - prev_dist;
        ax += round_div((x - prev_x) * 256 * num, den);
        ay += round_div((y - prev_y) * 256 * num, den);
      end
      hit = 1'b1;
    end
    if (hit) begin
      steer_q.push_back(make_steer(heading_angle(ax, ay), 1'b1));
      answered = 1'b1;
      if (last) clear_path();
      return;
    end
    prev_x = x;
    prev_y = y;
    prev_dist = d;
    if (last) begin
      steer_q.push_back(make_steer(0, 1'b0));
      clear_path();
    end
  endfunction

  // called at a rising edge; leaves valid high so a back-to-back word needs no toggle
  task automatic send_point(longint x, longint y, bit last);
    int gap;
    gap = in_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x[CW-1:0];
    point_y <= y[CW-1:0];
    last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_point(x, y, last);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, longint val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val[31:0];
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LOOKAHEAD: la_mm = val & 64'h7FFFF;
      REG_TOLERANCE: tol_mm = val & 64'h3FF;
      REG_MAX_ANGLE: max_ang = val & 64'h7FFF;
      default: ;
    endcase
  endtask

  task automatic configure(longint la, longint tol, longint mx);
    wait_idle();
    apb_write(REG_LOOKAHEAD, la);
    apb_write(REG_TOLERANCE, tol);
    apb_write(REG_MAX_ANGLE, mx);
  endtask

  function automatic longint sat_coord(longint v);
    return v > XMAX ? XMAX : (v < XMIN ? XMIN : v);
  endfunction

  task automatic test_directed();
    configure(3000, 1, 3574);
    send_point(0, 3000, 1'b1);              // exactly on the circle
    send_point(0, 2999, 1'b0);              // within tolerance
    send_point(100, 5000, 1'b0);            // ignored after the hit
    send_point(7, 7, 1'b1);
    send_point(0, 6000, 1'b1);              // beyond: interpolate from the origin
    send_point(500, 1000, 1'b0);
    send_point(-900, 2000, 1'b0);
    send_point(-4000, 4000, 1'b1);          // interpolate between two points
    send_point(10, 10, 1'b0);
    send_point(-20, 100, 1'b1);             // path exhausted
    send_point(0, -3000, 1'b1);             // straight back
    send_point(-1, -3000, 1'b1);
    send_point(1, -3000, 1'b1);
    send_point(3000, 0, 1'b1);
    send_point(-3000, 0, 1'b1);
    send_point(XMIN, XMIN, 1'b1);
    send_point(XMAX, XMAX, 1'b1);
    send_point(XMIN, XMAX, 1'b1);
    send_point(XMAX, XMIN, 1'b1);
    configure(0, 0, 1);
    send_point(0, 0, 1'b1);                 // hit at the origin
    send_point(-1, 0, 1'b1);
    configure(524287, 1023, 25736);
    send_point(XMAX, 0, 1'b0);
    send_point(XMIN, XMIN, 1'b1);
    send_point(0, XMIN, 1'b1);
  endtask

  task automatic random_paths(int n_items);
    int sent, plen, kind;
    longint x, y, r;
    sent = 0;
    while (sent < n_items) begin
      plen = $urandom_range(1, 6);
      for (int i = 0; i < plen; i++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          x = longint'(int'($urandom_range(0, 1048575))) - 524288;
          y = longint'(int'($urandom_range(0, 1048575))) - 524288;
        end else if (kind == 1) begin
          r = $urandom_range(0, 1) ? la_mm : -la_mm;
          if ($urandom_range(0, 1)) begin
            x = 0;
            y = sat_coord(r);
          end else begin
            x = sat_coord(r);
            y = 0;
          end
        end else begin
          // grow the radius along the path so most paths cross the look-ahead
          r = (la_mm * longint'((i + 1) * $urandom_range(2, 7))) / (longint'(plen) * 4)
              + $urandom_range(0, 15);
          x = sat_coord(r * (longint'($urandom_range(0, 2048)) - 1024) / 1024);
          y = sat_coord(r * (longint'($urandom_range(0, 2048)) - 1024) / 1024);
        end
        send_point(x, y, i == plen - 1);
        sent++;
      end
    end
  endtask

  task automatic test_config_sweep();
    configure(3000, 1, 3574);
    random_paths(100);
    configure(524287, 0, 1);
    random_paths(60);
    configure(0, 1023, 25736);
    random_paths(60);
    configure(1, 0, 25736);
    random_paths(40);
    configure($urandom_range(0, 524287), $urandom_range(0, 1023), $urandom_range(1, 25736));
    random_paths(80);
  endtask

  task automatic test_no_idle();
    configure(20000, 3, 6000);
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    random_paths(100);
    in_gaps = 1'b1;
    random_paths(60);
    out_stalls = 1'b1;
    configure($urandom_range(1000, 300000), $urandom_range(0, 50), $urandom_range(1, 25736));
    random_paths(100);
  endtask

  // sink: check each steering word, then draw the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      if (steer_q.size() == 0) begin
        $error("steering word with nothing expected");
        fail_cnt++;
      end else begin
        if (steer_angle !== steer_q[0].angle) begin
          $error("steer_angle exp %0d got %0d", steer_q[0].angle, steer_angle);
          fail_cnt++;
        end
        if (steer_fraction !== steer_q[0].fraction) begin
          $error("steer_fraction exp %0d got %0d", steer_q[0].fraction, steer_fraction);
          fail_cnt++;
        end
        if (point_found !== steer_q[0].found) begin
          $error("point_found exp %0d got %0d", steer_q[0].found, point_found);
          fail_cnt++;
        end
        void'(steer_q.pop_front());
      end
      stall_left = out_stalls ? $urandom_range(0, 3) : 0;
      out_ready <= (stall_left == 0);
    end else begin
      if (stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    la_mm = 3000;
    tol_mm = 1;
    max_ang = 3574;
    clear_path();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_no_idle();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/pps_pkg.sv
sv/pps_dp.sv
sv/pps_ctrl.sv
sv/pure_pursuit_lookahead_steer_top.sv
dv/pure_pursuit_lookahead_steer_top_tb.sv
